// ----- src/fcw_pkg.sv -----
// Shared types, constants and the Gaussian table generator for the confidence weight unit.
`timescale 1ns / 1ps

package fcw_pkg;

  // Field widths.
  localparam int RES_W   = 16;
  localparam int SIGMA_W = 16;
  localparam int W_W     = 16;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_ADDR_W = 3;

  // Default Gaussian table size, log2 of the entry count.
  localparam int GAUSS_TABLE_BITS_DEF = 11;

  // Q1.15 one and the rounding half.
  localparam logic [W_W-1:0] ONE_Q15  = 16'h8000;
  localparam logic [31:0]    HALF_Q15 = 32'd16384;

  // Divider shape: twelve quotient bits (Q3.8 plus the saturation bit).
  localparam int Q_W        = 12;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;
  localparam int DIV_W      = RES_W + 8;
  localparam int CMP_W      = DIV_W + 3;

  // Track factor in tenths: a floor, which is also the count at which it saturates, and a full factor.
  localparam int TF_W = 4;
  localparam logic [TF_W-1:0] TF_BASE = 4'd5;
  localparam logic [TF_W-1:0] TF_FULL = 4'd10;

  // Floor division by ten as a multiply by a rounded-up reciprocal; exact below 2^19.
  localparam int NUM_W       = 20;
  localparam int RECIP_SHIFT = 22;
  localparam logic [18:0] RECIP_10 = 19'd419431;
  localparam logic [NUM_W-1:0] BLEND_ROUND = 20'd5;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WEIGHT_ENABLE = 3'd0,
    CFG_STEREO_ENABLE = 3'd1,
    CFG_FLOW_SIGMA    = 3'd2,
    CFG_STEREO_SIGMA  = 3'd3,
    CFG_MIN_WEIGHT    = 3'd4,
    CFG_LOW_THRESHOLD = 3'd5,
    CFG_DECAY_FACTOR  = 3'd6
  } cfg_reg_e;

  // Limit a Q1.15 register value to one.
  function automatic logic [W_W-1:0] sat_one(input logic [CFG_W-1:0] v);
    logic [W_W-1:0] r;
    r = (v > ONE_Q15) ? ONE_Q15 : v;
    return r;
  endfunction

  // One table entry, round(32768 * exp(-0.5 * (8 i / 2^bits)^2)), built from a
  // Q31 Taylor series of exp(-i^2 / 2^(2 bits)) raised to the 32nd power by
  // five truncated squarings. Evaluated only at elaboration.
  function automatic logic [W_W-1:0] gauss_entry(input logic [31:0] idx, input int tbits);
    logic [63:0]        y;
    logic [63:0]        term;
    logic [63:0]        quo;
    logic [63:0]        rem;
    logic [63:0]        g;
    logic [63:0]        rnd;
    logic signed [63:0] sum;
    logic               done;
    y    = ({32'd0, idx} * {32'd0, idx}) << (32 - 2 * tbits);
    term = 64'h0000_0000_8000_0000;
    sum  = $signed(term);
    done = 1'b0;
    for (int k = 1; k <= 40; k++) begin
      if (!done) begin
        term = (term * y) >> 32;
        // Long division of the term by the series index, one bit a step.
        quo = '0;
        rem = '0;
        for (int bt = 31; bt >= 0; bt--) begin
          rem = {rem[62:0], term[bt]};
          if (rem >= 64'(unsigned'(k))) begin
            rem     = rem - 64'(unsigned'(k));
            quo[bt] = 1'b1;
          end
        end
        term = quo;
        if (term == 64'd0) begin
          done = 1'b1;
        end else if ((k % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    g = unsigned'(sum);
    if (g > 64'h0000_0000_8000_0000) begin
      g = 64'h0000_0000_8000_0000;
    end
    for (int s = 0; s < 5; s++) begin
      g = (g * g) >> 31;
    end
    rnd = (g * 64'd32768 + 64'h0000_0000_4000_0000) >> 31;
    return rnd[W_W-1:0];
  endfunction

endpackage

// ----- src/feature_confidence_weight_unit.sv -----
// Top level of the feature confidence weight unit: a ten-stage pipeline.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// config    in         cfg_we_i                 cfg_addr_i, cfg_wdata_i
// feature   in         start_i while !busy_o    flow/stereo residual, track count, present
// weight    out        done_o, one-cycle pulse  weight_o
//
// One feature transaction enters every cycle; busy_o never rises.
// Each weight passes through four divider stages (three quotient bits each),
// the registered table read, the factor product, the blend numerator, the
// divide by ten, the decay, and the clamp register.
// Reset clears the valid bits and loads the register defaults; there is no
// stall, since the receiver takes every done_o pulse.
module feature_confidence_weight_unit
  #(
    parameter int GAUSS_TABLE_BITS = fcw_pkg::GAUSS_TABLE_BITS_DEF
  )
  (
    input  logic                           clk_i,
    input  logic                           rst_ni,
    input  logic                           cfg_we_i,
    input  logic [fcw_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
    input  logic [fcw_pkg::CFG_W-1:0]      cfg_wdata_i,
    input  logic                           start_i,
    output logic                           busy_o,
    input  logic [fcw_pkg::RES_W-1:0]      flow_residual_i,
    input  logic [fcw_pkg::RES_W-1:0]      stereo_residual_i,
    input  logic [fcw_pkg::CNT_W-1:0]      track_count_i,
    input  logic                           stereo_present_i,
    output logic                           done_o,
    output logic [fcw_pkg::W_W-1:0]        weight_o
  );

  import fcw_pkg::*;

  localparam int GAUSS_DEPTH = 1 << GAUSS_TABLE_BITS;
  localparam int IDX_W       = Q_W - 1 + GAUSS_TABLE_BITS;

  // Configuration registers.
  logic                 weight_enable_q;
  logic                 stereo_enable_q;
  logic [SIGMA_W-1:0]   flow_sigma_q;
  logic [SIGMA_W-1:0]   stereo_sigma_q;
  logic [W_W-1:0]       min_weight_q;
  logic [W_W-1:0]       low_threshold_q;
  logic [W_W-1:0]       decay_factor_q;
  logic [SIGMA_W-1:0]   sigma_wr;

  // Divider stages.
  logic [DIV_W-1:0]      div_rem_q [DIV_STAGES][2];
  logic [Q_W-1:0]        div_quo_q [DIV_STAGES][2];
  logic [DIV_W-1:0]      div_rem_d [DIV_STAGES][2];
  logic [Q_W-1:0]        div_quo_d [DIV_STAGES][2];
  logic [DIV_STAGES-1:0] div_vld_q;
  logic [DIV_STAGES-1:0] div_use_q;
  logic [TF_W-1:0]       div_tf_q [DIV_STAGES];
  logic [SIGMA_W-1:0]    sigma_sel [2];
  logic [TF_W-1:0]       track_tenths;
  logic                  stereo_use;

  // Table read stage.
  logic [W_W-1:0]             gauss_rom [GAUSS_DEPTH];
  logic [IDX_W-1:0]           idx_wide [2];
  logic [GAUSS_TABLE_BITS-1:0] rom_idx [2];
  logic [W_W-1:0]             rom_q [2];
  logic [1:0]                 rom_zero_q;
  logic                       rom_vld_q;
  logic                       rom_use_q;
  logic [TF_W-1:0]            rom_tf_q;

  // Product, blend, divide by ten, decay and output stages.
  logic [W_W-1:0]   flow_fac;
  logic [W_W-1:0]   stereo_fac;
  logic [31:0]      prod_full;
  logic [W_W-1:0]   prod_q;
  logic             prod_vld_q;
  logic [TF_W-1:0]  prod_tf_q;
  logic [NUM_W-1:0] num_d;
  logic [NUM_W-1:0] num_q;
  logic             num_vld_q;
  logic [39:0]      recip_full;
  logic [W_W-1:0]   blend_q;
  logic             blend_vld_q;
  logic [31:0]      decay_full;
  logic [W_W-1:0]   decay_d;
  logic [W_W-1:0]   decay_q;
  logic             decay_vld_q;
  logic [W_W-1:0]   clamp_hi;
  logic [W_W-1:0]   weight_d;
  logic [W_W-1:0]   weight_q;
  logic             done_q;

  // Every cycle is open to a new transaction.
  assign busy_o = 1'b0;

  // A zero sigma divides as one.
  assign sigma_wr = (cfg_wdata_i == '0) ? SIGMA_W'(1) : cfg_wdata_i;

  // Register writes; the Q1.15 registers are stored already limited to one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_enable_q <= 1'b1;
      stereo_enable_q <= 1'b0;
      flow_sigma_q    <= 16'd256;
      stereo_sigma_q  <= 16'd256;
      min_weight_q    <= 16'd3277;
      low_threshold_q <= 16'd9830;
      decay_factor_q  <= 16'd16384;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_WEIGHT_ENABLE: weight_enable_q <= cfg_wdata_i[0];
        CFG_STEREO_ENABLE: stereo_enable_q <= cfg_wdata_i[0];
        CFG_FLOW_SIGMA:    flow_sigma_q    <= sigma_wr;
        CFG_STEREO_SIGMA:  stereo_sigma_q  <= sigma_wr;
        CFG_MIN_WEIGHT:    min_weight_q    <= sat_one(cfg_wdata_i);
        CFG_LOW_THRESHOLD: low_threshold_q <= sat_one(cfg_wdata_i);
        CFG_DECAY_FACTOR:  decay_factor_q  <= sat_one(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Track factor in tenths, min(10, 5 + count), and the stereo gate.
  assign track_tenths = (track_count_i >= CNT_W'(TF_BASE)) ? TF_FULL
                                                           : TF_BASE + {1'b0, track_count_i[2:0]};
  assign stereo_use   = stereo_enable_q & stereo_present_i;

  assign sigma_sel[0] = flow_sigma_q;
  assign sigma_sel[1] = stereo_sigma_q;

  // Restoring division of residual * 256 by sigma, three quotient bits per stage.
  // The top quotient bit set means the ratio reached 8 and saturates.
  always_comb begin
    logic [CMP_W-1:0] part;
    logic [CMP_W-1:0] sub;
    for (int g = 0; g < DIV_STAGES; g++) begin
      for (int l = 0; l < 2; l++) begin
        if (g == 0) begin
          part = (l == 0) ? CMP_W'({flow_residual_i, 8'h00})
                          : CMP_W'({stereo_residual_i, 8'h00});
          div_quo_d[g][l] = '0;
        end else begin
          part = CMP_W'(div_rem_q[g-1][l]);
          div_quo_d[g][l] = div_quo_q[g-1][l];
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
          sub = CMP_W'(sigma_sel[l]) << (Q_W - 1 - g * DIV_STEPS - j);
          if (part >= sub) begin
            part = part - sub;
            div_quo_d[g][l][Q_W-1-g*DIV_STEPS-j] = 1'b1;
          end
        end
        div_rem_d[g][l] = part[DIV_W-1:0];
      end
    end
  end

  // Divider valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= '0;
    end else begin
      div_vld_q <= {div_vld_q[DIV_STAGES-2:0], start_i & ~busy_o};
    end
  end

  // Divider payload.
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < DIV_STAGES; g++) begin
      for (int l = 0; l < 2; l++) begin
        div_rem_q[g][l] <= div_rem_d[g][l];
        div_quo_q[g][l] <= div_quo_d[g][l];
      end
      if (g == 0) begin
        div_tf_q[g]  <= track_tenths;
        div_use_q[g] <= stereo_use;
      end else begin
        div_tf_q[g]  <= div_tf_q[g-1];
        div_use_q[g] <= div_use_q[g-1];
      end
    end
  end

  // Gaussian table, fixed at elaboration.
  for (genvar e = 0; e < GAUSS_DEPTH; e++) begin : g_rom
    localparam logic [W_W-1:0] ENTRY = gauss_entry(32'(e), GAUSS_TABLE_BITS);
    assign gauss_rom[e] = ENTRY;
  end

  // Table index is q scaled from 2048 steps to the table size.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      idx_wide[l] = {div_quo_q[DIV_STAGES-1][l][Q_W-2:0], {GAUSS_TABLE_BITS{1'b0}}};
      rom_idx[l]  = idx_wide[l][IDX_W-1:Q_W-1];
    end
  end

  // Registered table read.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      rom_q[l]      <= gauss_rom[rom_idx[l]];
      rom_zero_q[l] <= div_quo_q[DIV_STAGES-1][l][Q_W-1];
    end
    rom_use_q <= div_use_q[DIV_STAGES-1];
    rom_tf_q  <= div_tf_q[DIV_STAGES-1];
  end

  // Product of the two factors; the stereo factor is one when not in use.
  assign flow_fac   = rom_zero_q[0] ? '0 : rom_q[0];
  assign stereo_fac = !rom_use_q ? ONE_Q15 : (rom_zero_q[1] ? '0 : rom_q[1]);
  assign prod_full  = 32'(flow_fac) * 32'(stereo_fac) + HALF_Q15;

  // Blend numerator toward the floor by the track factor.
  assign num_d = NUM_W'(prod_tf_q) * NUM_W'(prod_q)
               + NUM_W'(TF_FULL - prod_tf_q) * NUM_W'(min_weight_q) + BLEND_ROUND;

  // Floor division of the numerator by ten.
  assign recip_full = 40'(num_q) * 40'(RECIP_10);

  // Decay of low weights.
  assign decay_full = 32'(blend_q) * 32'(decay_factor_q) + HALF_Q15;
  assign decay_d    = (blend_q < low_threshold_q) ? decay_full[30:15] : blend_q;

  // Clamp to the floor and to one; a disabled unit gives one.
  assign clamp_hi = (decay_q > ONE_Q15) ? ONE_Q15 : decay_q;
  assign weight_d = !weight_enable_q ? ONE_Q15
                  : ((clamp_hi < min_weight_q) ? min_weight_q : clamp_hi);

  // Back-end valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_vld_q   <= 1'b0;
      prod_vld_q  <= 1'b0;
      num_vld_q   <= 1'b0;
      blend_vld_q <= 1'b0;
      decay_vld_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      rom_vld_q   <= div_vld_q[DIV_STAGES-1];
      prod_vld_q  <= rom_vld_q;
      num_vld_q   <= prod_vld_q;
      blend_vld_q <= num_vld_q;
      decay_vld_q <= blend_vld_q;
      done_q      <= decay_vld_q;
    end
  end

  // Back-end payload.
  always_ff @(posedge clk_i) begin
    prod_q    <= prod_full[30:15];
    prod_tf_q <= rom_tf_q;
    num_q     <= num_d;
    blend_q   <= recip_full[RECIP_SHIFT+W_W-1:RECIP_SHIFT];
    decay_q   <= decay_d;
    weight_q  <= weight_d;
  end

  assign done_o   = done_q;
  assign weight_o = weight_q;

`ifndef NO_ASSERTIONS
  // A delivered weight lies between the floor in force and one.
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (weight_o <= ONE_Q15) && (weight_o >= $past(min_weight_q)))
    else $error("weight outside [min_weight, one]");

  // With weighting off the result is exactly one.
  a_disabled_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(weight_enable_q)) |-> (weight_o == ONE_Q15))
    else $error("disabled unit gave a weight other than one");

  // The rounded factor product never exceeds one.
  a_prod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q |-> (prod_q <= ONE_Q15))
    else $error("factor product above one");
`endif

endmodule
